// ----- design/akma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package akma_pkg;
  localparam int NumKeys = 8;
  localparam int KeyW = 3;
  localparam int FracBits = 16;
  localparam int NumAxes = 4;
  localparam int GainFrac = 16;
  localparam logic signed [15:0] LevelReset = 16'sd10000;

  localparam logic [2:0] RegBottom = 3'd0;
  localparam logic [2:0] RegTop = 3'd1;
  localparam logic [2:0] RegWindow = 3'd2;
  localparam logic [2:0] RegGainX = 3'd3;
  localparam logic [2:0] RegGainY = 3'd4;
  localparam logic [2:0] RegGainH = 3'd5;
  localparam logic [2:0] RegGainV = 3'd6;

  localparam logic CmdSample = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic start;
    logic [15:0] num;
    logic [14:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [FracBits:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- design/akma_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: round((num << FracBits) / den), one quotient bit a cycle.
module akma_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire akma_pkg::div_req_t req,
  output akma_pkg::div_rsp_t    rsp
);
  localparam int QW = akma_pkg::FracBits + 1;
  logic [QW-1:0] quo;
  logic [16:0] rem;
  logic [5:0] cnt;
  logic busy;
  logic done;
  logic [14:0] den;
  logic [15:0] num;
  logic [16:0] trial;
  logic [QW:0] rounded;

  always_comb begin
    trial = {rem[15:0], (cnt >= 6'(QW)) ? num[4'(cnt - 6'(QW))] : 1'b0};
    rounded = {1'b0, quo} + {{QW{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt <= 6'd16 + 6'(QW) - 6'd1;
        rem <= '0;
        quo <= '0;
        num <= req.num;
        den <= req.den;
      end else if (busy) begin
        // Quotient carries one extra bit below the point for rounding.
        if (cnt >= 6'(QW)) begin
          rem <= trial;
        end else begin
          if (trial >= {2'b00, den}) begin
            rem <= trial - {2'b00, den};
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[QW-2:0], 1'b0};
          end
        end
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = rounded[QW:1];
endmodule
`default_nettype wire

// ----- design/analog_key_mouse_accumulator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Analog key to mouse motion accumulator.
// The input stream carries sample and tick words; a sample stores one key level,
// a tick folds every key's deflection into the four axis sums and may close the
// report window. The output stream carries report words: wheel reports only when
// their sum is nonzero, then X, then Y with tlast set.
// Configuration is a plain write port; the user writes it only while idle (not enforced).
// A sample is stored when it is accepted. A tick walks the keys in turn through StKey
// and StWait, paced by the single shared divider that needs 33 steps per key (a key
// that needs no division skips it), then checks the window in StWin and, for a burst,
// passes each report through StMul and StRep on the shared multiplier, a skipped wheel
// report through StMul alone, and StRep holds while the receiver stalls. s_tready is
// low while an item is worked on, so one item is handled at a time.
// Each finished report waits in the output register; while the receiver stalls
// the sequencer holds. Reset sets every key level to 10000, clears the sums and
// the window, and loads the register defaults.
module analog_key_mouse_accumulator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command, key_index, key_level, now_ms (from bit 0), zero padded to 56 bits
  input  wire logic [55:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // axis, motion (from bit 0), zero padded to 24 bits
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StKey = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StWin = 3'd3;
  localparam logic [2:0] StMul = 3'd4;
  localparam logic [2:0] StRep = 3'd5;
  localparam logic [2:0] StOut = 3'd6;

  logic [2:0] state;
  logic [14:0] travel_bottom;
  logic [14:0] travel_top;
  logic [15:0] window_ms;
  logic signed [23:0] gains [akma_pkg::NumAxes];
  logic signed [15:0] key_levels [akma_pkg::NumKeys];
  logic signed [31:0] axis_sums [akma_pkg::NumAxes];
  logic [31:0] window_start;
  logic [31:0] now;
  logic [akma_pkg::KeyW-1:0] key;
  logic [1:0] rep;
  logic signed [56:0] prod;

  logic in_cmd;
  logic [2:0] in_key;
  logic signed [15:0] in_level;
  logic [31:0] in_now;
  assign in_cmd = s_tdata[0];
  assign in_key = s_tdata[3:1];
  assign in_level = s_tdata[19:4];
  assign in_now = s_tdata[51:20];

  akma_pkg::div_req_t div_req;
  akma_pkg::div_rsp_t div_rsp;
  akma_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic signed [16:0] diff;
  logic [15:0] span;
  logic degenerate;
  logic [1:0] pair;
  logic [16:0] defl;
  logic signed [33:0] sum_ext;
  logic signed [33:0] new_sum;
  logic [31:0] elapsed;
  logic any_nz;
  logic [1:0] rep_axis;
  logic rep_ok;
  logic [1:0] rep_code;
  logic neg;
  logic [56:0] mag;
  logic [24:0] rnd;
  logic signed [15:0] motion;

  always_comb begin
    diff = 17'(key_levels[key]) - $signed({2'b00, travel_bottom});
    span = {1'b0, travel_top} - {1'b0, travel_bottom};
    degenerate = travel_top <= travel_bottom;
    pair = key[2:1];
    div_req.start = (state == StKey) && !degenerate && diff > 0 && $signed({1'b0, diff}) <
                    $signed({2'b00, span});
    div_req.num = diff[15:0];
    div_req.den = span[14:0];
    if (degenerate) defl = (diff < 0) ? 17'h10000 : 17'd0;
    else if (diff <= 0) defl = 17'h10000;
    else if ($signed({1'b0, diff}) >= $signed({2'b00, span})) defl = 17'd0;
    else if (div_rsp.quo >= 17'h10000) defl = 17'd0;
    else defl = 17'h10000 - div_rsp.quo;
    sum_ext = 34'(axis_sums[pair]);
    new_sum = key[0] ? sum_ext + $signed({17'd0, defl}) : sum_ext - $signed({17'd0, defl});
    elapsed = now - window_start;
    any_nz = 1'b0;
    for (int i = 0; i < akma_pkg::NumAxes; i++) any_nz = any_nz | (axis_sums[i] != 32'sd0);
    unique case (rep)
      2'd0: begin rep_axis = 2'd2; rep_ok = axis_sums[2] != 0; end
      2'd1: begin rep_axis = 2'd3; rep_ok = axis_sums[3] != 0; end
      2'd2: begin rep_axis = 2'd0; rep_ok = 1'b1; end
      default: begin rep_axis = 2'd1; rep_ok = 1'b1; end
    endcase
    rep_code = rep;
    neg = prod < 0;
    mag = neg ? 57'(-prod) : 57'(prod);
    rnd = 25'((mag + (57'd1 << 31)) >> 32);
    if (neg) motion = (rnd > 25'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, rnd}));
    else motion = (rnd > 25'd32767) ? 16'sd32767 : 16'(rnd);
  end

  assign s_tready = (state == StIdle);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      m_tvalid <= 1'b0;
      travel_bottom <= 15'd0;
      travel_top <= 15'd32767;
      window_ms <= 16'd10;
      window_start <= '0;
      for (int i = 0; i < akma_pkg::NumAxes; i++) begin
        gains[i] <= 24'sd65536;
        axis_sums[i] <= '0;
      end
      for (int i = 0; i < akma_pkg::NumKeys; i++) key_levels[i] <= akma_pkg::LevelReset;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          akma_pkg::RegBottom: travel_bottom <= cfg_data[14:0];
          akma_pkg::RegTop: travel_top <= cfg_data[14:0];
          akma_pkg::RegWindow: window_ms <= cfg_data[15:0];
          akma_pkg::RegGainX: gains[0] <= cfg_data;
          akma_pkg::RegGainY: gains[1] <= cfg_data;
          akma_pkg::RegGainH: gains[2] <= cfg_data;
          akma_pkg::RegGainV: gains[3] <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != StRep) m_tvalid <= 1'b0;
      unique case (state)
        StIdle: begin
          if (s_tvalid) begin
            if (in_cmd == akma_pkg::CmdSample) begin
              key_levels[in_key] <= in_level;
            end else begin
              now <= in_now;
              key <= '0;
              state <= StKey;
            end
          end
        end
        StKey: state <= StWait;
        StWait: begin
          if (!div_rsp.busy) begin
            if (new_sum > 34'sh7FFFFFFF) axis_sums[pair] <= 32'sh7FFFFFFF;
            else if (new_sum < -34'sh80000000) axis_sums[pair] <= 32'sh80000000;
            else axis_sums[pair] <= new_sum[31:0];
            if (key == 3'(akma_pkg::NumKeys - 1)) begin
              state <= StWin;
              if (window_start == 0) window_start <= now;
            end else begin
              key <= key + 3'd1;
              state <= StKey;
            end
          end
        end
        StWin: begin
          if (elapsed < {16'd0, window_ms}) state <= StIdle;
          else begin
            window_start <= '0;
            rep <= 2'd0;
            state <= any_nz ? StMul : StIdle;
          end
        end
        StMul: begin
          if (rep_ok) begin
            prod <= 57'(axis_sums[rep_axis]) * 57'(gains[rep_axis]);
            state <= StRep;
          end else begin
            rep <= rep + 2'd1;
          end
        end
        StRep: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {6'd0, motion, rep_code};
            m_tlast <= (rep == 2'd3);
            if (rep == 2'd3) begin
              for (int i = 0; i < akma_pkg::NumAxes; i++) axis_sums[i] <= '0;
              state <= StIdle;
            end else begin
              rep <= rep + 2'd1;
              state <= StMul;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  property p_busy_not_ready;
    @(posedge clk) disable iff (rst) (state != StIdle) |-> !s_tready;
  endproperty
  a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");
  a_last_is_y: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[1:0] == 2'd3)) else $error("last not on Y");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
endmodule
`default_nettype wire
